/* src/agfs_pkg.sv */
package agfs_pkg;

  localparam int SAMPLE_W = 10;
  localparam int VALUE_W  = 11;
  localparam int IDX_W    = 4;

  // Input selector carried in tuser.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // Result kinds carried in tuser.
  localparam logic [1:0] KIND_AGAIN = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;

  // Gain request from the magnitude compare.
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_UP   = 2'd1;
  localparam logic [1:0] REQ_DOWN = 2'd2;

  // Direction of the last gain step within a point.
  localparam logic [1:0] MOVE_NONE    = 2'd0;
  localparam logic [1:0] MOVE_RAISED  = 2'd1;
  localparam logic [1:0] MOVE_LOWERED = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_UPPER    = 2'd0;
  localparam logic [1:0] REG_LOWER    = 2'd1;
  localparam logic [1:0] REG_GAIN_TOP = 2'd2;

  localparam logic [SAMPLE_W-1:0] UPPER_RESET    = 10'd900;
  localparam logic [SAMPLE_W-1:0] LOWER_RESET    = 10'd100;
  localparam logic [IDX_W-1:0]    GAIN_TOP_RESET = 4'd7;

  // Packet tag that seeds the check byte (ASCII lowercase f).
  localparam logic [7:0] PACKET_TAG = 8'h66;

  typedef struct packed {
    logic [SAMPLE_W-1:0] upper;
    logic [SAMPLE_W-1:0] lower;
    logic [IDX_W-1:0]    gain_top;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] freq;
    logic [IDX_W-1:0] gain;
    logic [1:0]       move;
    logic             active;
  } state_t;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] offset;
    logic [SAMPLE_W-1:0] i_smp;
    logic [SAMPLE_W-1:0] q_smp;
  } item_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [IDX_W-1:0]          freq;
    logic [IDX_W-1:0]          gain;
    logic signed [VALUE_W-1:0] i_value;
    logic signed [VALUE_W-1:0] q_value;
    logic [7:0]                setting;
    logic [7:0]                check;
    logic                      last;
  } result_t;

endpackage

/* src/agfs_cfg.sv */
module agfs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [agfs_pkg::SAMPLE_W-1:0] wr_data,
  output agfs_pkg::cfg_t                cfg
);

  agfs_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper    <= agfs_pkg::UPPER_RESET;
      cfg_r.lower    <= agfs_pkg::LOWER_RESET;
      cfg_r.gain_top <= agfs_pkg::GAIN_TOP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        agfs_pkg::REG_UPPER:    cfg_r.upper    <= wr_data;
        agfs_pkg::REG_LOWER:    cfg_r.lower    <= wr_data;
        agfs_pkg::REG_GAIN_TOP: cfg_r.gain_top <= wr_data[agfs_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* src/agfs_step.sv */
module agfs_step (
  input  agfs_pkg::item_t                item,
  input  agfs_pkg::state_t               state,
  input  agfs_pkg::cfg_t                 cfg,
  input  logic [agfs_pkg::IDX_W-1:0]     start_freq,
  output agfs_pkg::state_t               state_nxt,
  output agfs_pkg::result_t              res
);

  logic signed [agfs_pkg::VALUE_W-1:0] i_diff;
  logic signed [agfs_pkg::VALUE_W-1:0] q_diff;
  logic [agfs_pkg::SAMPLE_W-1:0]       i_mag;
  logic [agfs_pkg::SAMPLE_W-1:0]       q_mag;
  logic [agfs_pkg::SAMPLE_W-1:0]       mag;
  logic [1:0]                          req;
  logic                                finish;
  logic [agfs_pkg::IDX_W-1:0]          gain_new;
  logic [1:0]                          move_new;
  logic [7:0]                          setting;
  logic [7:0]                          i_hi;
  logic [7:0]                          q_hi;

  assign i_diff = $signed({1'b0, item.i_smp}) - $signed({1'b0, item.offset});
  assign q_diff = $signed({1'b0, item.q_smp}) - $signed({1'b0, item.offset});

  // Magnitude of an 11-bit difference never exceeds 1023.
  assign i_mag = i_diff[agfs_pkg::VALUE_W-1] ? agfs_pkg::SAMPLE_W'(-i_diff)
                                             : i_diff[agfs_pkg::SAMPLE_W-1:0];
  assign q_mag = q_diff[agfs_pkg::VALUE_W-1] ? agfs_pkg::SAMPLE_W'(-q_diff)
                                             : q_diff[agfs_pkg::SAMPLE_W-1:0];
  assign mag   = (q_mag > i_mag) ? q_mag : i_mag;

  // The upper threshold wins when both are crossed.
  assign req = (mag > cfg.upper) ? agfs_pkg::REQ_DOWN :
               (mag < cfg.lower) ? agfs_pkg::REQ_UP   : agfs_pkg::REQ_NONE;

  always_comb begin
    finish   = 1'b0;
    gain_new = state.gain;
    move_new = state.move;
    case (req)
      agfs_pkg::REQ_UP: begin
        if (state.move == agfs_pkg::MOVE_LOWERED) begin
          finish = 1'b1;
        end else begin
          move_new = agfs_pkg::MOVE_RAISED;
          if (state.gain < cfg.gain_top) gain_new = state.gain + 4'd1;
          else finish = 1'b1;
        end
      end
      agfs_pkg::REQ_DOWN: begin
        if (state.move == agfs_pkg::MOVE_RAISED) begin
          finish = 1'b1;
        end else begin
          move_new = agfs_pkg::MOVE_LOWERED;
          if (state.gain != 4'd0) gain_new = state.gain - 4'd1;
          else finish = 1'b1;
        end
      end
      default: finish = 1'b1;
    endcase
  end

  assign setting = {state.freq, state.gain};
  // High bytes of the 16-bit sign-extended words.
  assign i_hi = {{5{i_diff[agfs_pkg::VALUE_W-1]}}, i_diff[10:8]};
  assign q_hi = {{5{q_diff[agfs_pkg::VALUE_W-1]}}, q_diff[10:8]};

  always_comb begin
    state_nxt = state;
    res       = '0;
    if (item.op == agfs_pkg::OP_START) begin
      state_nxt.freq   = start_freq;
      state_nxt.gain   = '0;
      state_nxt.move   = agfs_pkg::MOVE_NONE;
      state_nxt.active = 1'b1;
      res.kind         = agfs_pkg::KIND_AGAIN;
      res.freq         = start_freq;
    end else if (!state.active) begin
      res.kind = agfs_pkg::KIND_IDLE;
    end else if (!finish) begin
      state_nxt.gain = gain_new;
      state_nxt.move = move_new;
      res.kind       = agfs_pkg::KIND_AGAIN;
      res.freq       = state.freq;
      res.gain       = gain_new;
    end else begin
      // A finishing step never changes the gain.
      res.kind    = agfs_pkg::KIND_POINT;
      res.freq    = state.freq;
      res.gain    = state.gain;
      res.i_value = i_diff;
      res.q_value = q_diff;
      res.setting = setting;
      res.check   = agfs_pkg::PACKET_TAG ^ i_diff[7:0] ^ i_hi ^ q_diff[7:0] ^ q_hi ^ setting;
      res.last    = (state.freq == 4'd0);
      state_nxt.move = agfs_pkg::MOVE_NONE;
      if (state.freq == 4'd0) state_nxt.active = 1'b0;
      else state_nxt.freq = state.freq - 4'd1;
    end
  end

endmodule

/* src/autorange_gain_frequency_sweep_top.sv */
// Channel  Direction  tdata (low bit up)                                tuser  tlast
// in_      slave      offset[9:0] i[19:10] q[29:20] pad[31:30]          op     -
// out_     master     freq[3:0] gain[7:4] i[18:8] q[29:19]              kind   last_point
//                     setting[37:30] check[45:38] pad[47:46]
// cfg_     slave      cfg_index selects register, cfg_data is the value  -      -
//
// One beat per cycle is accepted when out_tready does not stall the result register.
// Throughput is set by the single compare and update step between the input
// register and the result register, which also updates the sweep state.
// Reset (rst_n low, synchronous) idles the sweep and restores the register defaults.
// A stall on out_tready holds both registers; in_tready stays high while a slot is free.
module autorange_gain_frequency_sweep_top #(
  parameter int NUM_POINTS = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // offset_sample, i_sample, q_sample
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // freq, gain, i, q, setting, check
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam logic [agfs_pkg::IDX_W-1:0] START_FREQ = agfs_pkg::IDX_W'(NUM_POINTS - 1);

  agfs_pkg::cfg_t    cfg;
  agfs_pkg::item_t   in_item_r;
  logic              in_valid_r;
  agfs_pkg::state_t  state_r;
  agfs_pkg::state_t  state_nxt;
  agfs_pkg::result_t res;
  agfs_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_fire;

  assign cfg_ready = 1'b1;

  agfs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  agfs_step u_step (
    .item       (in_item_r),
    .state      (state_r),
    .cfg        (cfg),
    .start_freq (START_FREQ),
    .state_nxt  (state_nxt),
    .res        (res)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.op     <= in_tuser;
      in_item_r.offset <= in_tdata[9:0];
      in_item_r.i_smp  <= in_tdata[19:10];
      in_item_r.q_smp  <= in_tdata[29:20];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {2'b00, out_res_r.check, out_res_r.setting, out_res_r.q_value,
                       out_res_r.i_value, out_res_r.gain, out_res_r.freq};

`ifndef SYNTHESIS
  // Sweep state moves only when an item passes into the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("sweep state changed without an item");

  // A start item always reloads the sweep at the top frequency with gain zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.op == agfs_pkg::OP_START) |=>
      state_r.active && (state_r.freq == START_FREQ) && (state_r.gain == 4'd0))
    else $error("start item did not reload the sweep");

  // Reporting the final point ends the sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res.kind == agfs_pkg::KIND_POINT) && res.last |=> !state_r.active)
    else $error("sweep still active after the last point");

  // Gain moves by at most one step per item outside of a start.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.op == agfs_pkg::OP_MEASURE) |=>
      (state_r.gain == $past(state_r.gain)) ||
      (state_r.gain == $past(state_r.gain) + 4'd1) ||
      (state_r.gain == $past(state_r.gain) - 4'd1))
    else $error("gain jumped by more than one step");
`endif

endmodule
